>>> rtl/interval_set_insert_find_defines.svh
// assertion macros for the interval set block
// used by the top level; no other dependencies
`ifndef INTERVAL_SET_INSERT_FIND_DEFINES_SVH
`define INTERVAL_SET_INSERT_FIND_DEFINES_SVH

// condition implies consequence in the same cycle
`define ISIF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define ISIF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/isif_pkg.sv
// shared constants and types for the interval set block
// no dependencies
`default_nettype none

package isif_pkg;

    localparam int MAX_N     = 64;
    localparam int ID_W      = 16;
    localparam int MEMBER_W  = 16;
    localparam int CNT_W     = $clog2(MAX_N + 1);
    localparam int OUT_CNT_W = 7;

    localparam logic REQ_FIND   = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // broadcast to every cell
    typedef struct packed {
        logic            cmp;
        logic            shift_up;
        logic            shift_dn;
        logic            ext_lo;
        logic            ext_hi;
        logic [ID_W-1:0] id;
    } t_cell_ctl;

    // compare flags held by each cell
    typedef struct packed {
        logic below;
        logic hit;
        logic adj_lo;
        logic adj_hi;
    } t_cell_stat;

endpackage

`default_nettype wire

>>> rtl/isif_if.sv
// request and response channel interfaces for the interval set block
// depends on isif_pkg
`default_nettype none

interface isif_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [isif_pkg::MEMBER_W-1:0] member_id;

    modport source (output valid, output req_type, output member_id, input ready);
    modport sink   (input valid, input req_type, input member_id, output ready);
endinterface

interface isif_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           was_present;
    logic                           full_error;
    logic [isif_pkg::OUT_CNT_W-1:0] intervals_used;

    modport source (output valid, output was_present, output full_error,
                    output intervals_used, input ready);
    modport sink   (input valid, input was_present, input full_error,
                    input intervals_used, output ready);
endinterface

`default_nettype wire

>>> rtl/isif_cell.sv
// one cell of the interval chain: holds one interval and its compare flags
// depends on isif_pkg
`default_nettype none

module isif_cell (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire isif_pkg::t_cell_ctl   i_ctl,
    input  wire                        i_valid,
    input  wire                        i_prev_below,
    input  wire  [isif_pkg::ID_W-1:0]  i_prev_low,
    input  wire  [isif_pkg::ID_W-1:0]  i_prev_high,
    input  wire  [isif_pkg::ID_W-1:0]  i_next_low,
    input  wire  [isif_pkg::ID_W-1:0]  i_next_high,
    output logic [isif_pkg::ID_W-1:0]  o_low,
    output logic [isif_pkg::ID_W-1:0]  o_high,
    output isif_pkg::t_cell_stat       o_stat
);
    import isif_pkg::*;

    logic [ID_W-1:0] r_low, n_low;
    logic [ID_W-1:0] r_high, n_high;
    t_cell_stat      r_stat, n_stat;
    logic [ID_W:0]   w_high_p1;
    logic [ID_W:0]   w_id_p1;

    assign w_high_p1 = {1'b0, r_high} + {{ID_W{1'b0}}, 1'b1};
    assign w_id_p1   = {1'b0, i_ctl.id} + {{ID_W{1'b0}}, 1'b1};

    always_comb begin
        n_stat = r_stat;
        if (i_ctl.cmp) begin
            n_stat.below  = i_valid && (r_high < i_ctl.id);
            n_stat.hit    = i_valid && (r_low <= i_ctl.id) && (i_ctl.id <= r_high);
            n_stat.adj_lo = i_valid && (w_high_p1 == {1'b0, i_ctl.id});
            n_stat.adj_hi = i_valid && (w_id_p1 == {1'b0, r_low});
        end
    end

    always_comb begin
        n_low  = r_low;
        n_high = r_high;
        priority if (i_ctl.shift_up) begin
            // cells at or above the insert point move up one place
            if (!r_stat.below) begin
                if (i_prev_below) begin
                    n_low  = i_ctl.id;
                    n_high = i_ctl.id;
                end else begin
                    n_low  = i_prev_low;
                    n_high = i_prev_high;
                end
            end
        end else if (i_ctl.shift_dn) begin
            // left neighbor absorbs the right one, the rest move down
            if (r_stat.adj_lo) begin
                n_high = i_next_high;
            end else if (!r_stat.below) begin
                n_low  = i_next_low;
                n_high = i_next_high;
            end
        end else if (i_ctl.ext_lo) begin
            if (r_stat.adj_lo) begin
                n_high = i_ctl.id;
            end
        end else if (i_ctl.ext_hi) begin
            if (r_stat.adj_hi) begin
                n_low = i_ctl.id;
            end
        end else begin
            // no update this cycle
            n_low  = r_low;
            n_high = r_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat <= '0;
        end else begin
            r_stat <= n_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low  <= n_low;
        r_high <= n_high;
    end

    assign o_low  = r_low;
    assign o_high = r_high;
    assign o_stat = r_stat;

endmodule

`default_nettype wire

>>> rtl/interval_set_insert_find.sv
// top level of the interval set: request/response control and the cell chain
// depends on isif_pkg, isif_if, isif_cell and the assertion macro header
//
//  channel | dir | payload                                        | handshake
//  i_req   | in  | req_type, member_id                            | valid/ready
//  o_rsp   | out | was_present, full_error, intervals_used         | valid/ready
//
// one request passes three steps: accept, a compare in which all cells compare
// against the identifier at once, and an update that reduces the flags and updates
// the chain (shift, merge or extend). the output register holds one word, so a
// new request is taken while the last response still waits; the update cycle
// waits only if that register is still full. reset clears the count and flags
`default_nettype none
`include "interval_set_insert_find_defines.svh"

module interval_set_insert_find (
    input  wire        i_clk,
    input  wire        i_rst_n,
    isif_req_if.sink   i_req,
    isif_rsp_if.source o_rsp
);
    import isif_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic             r_insert;
    logic [ID_W-1:0]  r_id;
    logic [CNT_W-1:0] r_count, n_count;

    logic                 r_out_valid, n_out_valid;
    logic                 r_out_present, r_out_full;
    logic [OUT_CNT_W-1:0] r_out_used;

    t_cell_ctl       w_ctl;
    logic [ID_W-1:0] w_low  [MAX_N];
    logic [ID_W-1:0] w_high [MAX_N];
    t_cell_stat      w_stat [MAX_N];
    logic [MAX_N-1:0] w_hit, w_adj_lo, w_adj_hi;

    logic w_accept, w_upd_fire;
    logic w_present, w_join_l, w_join_r, w_need_new, w_full;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_upd_fire  = (r_state == S_UPD) && (!r_out_valid || o_rsp.ready);

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < MAX_N; gi++) begin : g_cell
            logic            w_prev_below;
            logic [ID_W-1:0] w_prev_low, w_prev_high, w_next_low, w_next_high;
            logic            w_valid;

            assign w_valid = (CNT_W'(gi) < r_count);
            if (gi == 0) begin : g_first
                // first cell always sees a "below" neighbor so it can take a new head
                assign w_prev_below = 1'b1;
                assign w_prev_low   = '0;
                assign w_prev_high  = '0;
            end else begin : g_mid
                assign w_prev_below = w_stat[gi-1].below;
                assign w_prev_low   = w_low[gi-1];
                assign w_prev_high  = w_high[gi-1];
            end
            if (gi == MAX_N - 1) begin : g_last
                assign w_next_low  = '0;
                assign w_next_high = '0;
            end else begin : g_inner
                assign w_next_low  = w_low[gi+1];
                assign w_next_high = w_high[gi+1];
            end

            isif_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_valid      (w_valid),
                .i_prev_below (w_prev_below),
                .i_prev_low   (w_prev_low),
                .i_prev_high  (w_prev_high),
                .i_next_low   (w_next_low),
                .i_next_high  (w_next_high),
                .o_low        (w_low[gi]),
                .o_high       (w_high[gi]),
                .o_stat       (w_stat[gi])
            );

            assign w_hit[gi]    = w_stat[gi].hit;
            assign w_adj_lo[gi] = w_stat[gi].adj_lo;
            assign w_adj_hi[gi] = w_stat[gi].adj_hi;
        end
    endgenerate

    // decision from the flags captured in the compare cycle
    assign w_present  = |w_hit;
    assign w_join_l   = |w_adj_lo;
    assign w_join_r   = |w_adj_hi;
    assign w_need_new = (r_insert == REQ_INSERT) && !w_present && !w_join_l && !w_join_r;
    assign w_full     = w_need_new && (r_count >= CNT_W'(MAX_N));

    always_comb begin
        w_ctl          = '0;
        w_ctl.id       = r_id;
        w_ctl.cmp      = (r_state == S_CMP);
        if (w_upd_fire && (r_insert == REQ_INSERT) && !w_present) begin
            w_ctl.shift_dn = w_join_l && w_join_r;
            w_ctl.ext_lo   = w_join_l && !w_join_r;
            w_ctl.ext_hi   = w_join_r && !w_join_l;
            w_ctl.shift_up = w_need_new && !w_full;
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.shift_up) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.shift_dn) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_upd_fire) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && o_rsp.ready) n_out_valid = 1'b0;
        if (w_upd_fire) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_insert <= i_req.req_type;
            r_id     <= i_req.member_id[ID_W-1:0];
        end
        if (w_upd_fire) begin
            r_out_present <= w_present;
            r_out_full    <= w_full;
            r_out_used    <= OUT_CNT_W'(n_count);
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.was_present    = r_out_present;
    assign o_rsp.full_error     = r_out_full;
    assign o_rsp.intervals_used = r_out_used;

    `ISIF_ASSERT_SAME(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_N), "interval count above capacity")
    `ISIF_ASSERT_SAME(a_single_hit, i_clk, i_rst_n, r_state == S_UPD, $onehot0(w_hit) && $onehot0(w_adj_lo) && $onehot0(w_adj_hi), "more than one cell claims the identifier")
    `ISIF_ASSERT_SAME(a_full_cap, i_clk, i_rst_n, w_upd_fire && w_full, r_count == CNT_W'(MAX_N) && !w_present, "full flag without a full table")
    `ISIF_ASSERT_NEXT(a_upd_done, i_clk, i_rst_n, w_upd_fire, r_state == S_IDLE && r_out_valid, "update did not post a response word")

endmodule

`default_nettype wire
